// ===== hdl/ffba_pkg.sv =====
`default_nettype none
package ffba_pkg;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_INS_RD,
        S_INS_WR,
        S_SPLIT_HI,
        S_SPLIT_LO,
        S_NXT_RD,
        S_NXT_CHK,
        S_PRV_RD,
        S_PRV_CHK,
        S_REM_RD,
        S_REM_WR,
        S_DONE
    } t_state;

    typedef logic [2:0] t_status;

    localparam t_status ST_DONE      = 3'd0;
    localparam t_status ST_ZERO_SIZE = 3'd1;
    localparam t_status ST_NO_FIT    = 3'd2;
    localparam t_status ST_FULL      = 3'd3;
    localparam t_status ST_NOT_FOUND = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [7:0] THRESHOLD_RESET = 8'd12;

endpackage
`default_nettype wire

// ===== hdl/ffba_ram.sv =====
`default_nettype none
module ffba_ram #(
    parameter int WIDTH = 47,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/first_fit_block_allocator.sv =====
`default_nettype none
// Channel   | Direction | Handshake                    | Payload
// request   | in        | i_req_valid / o_req_ready    | i_opcode, i_request_bytes, i_block_offset
// response  | out       | o_rsp_valid / i_rsp_ready    | o_ok, o_status, o_granted_offset,
//           |           |                              | o_free_bytes, o_used_bytes
// config    | in        | i_cfg_we (no wait)           | i_cfg_wdata (split threshold)
//
// Every table read goes through the single registered read port of the table RAM. A request
// scans entries from index 0 until it finds its block; a split or a merge then moves the
// following entries one at a time, each read and then written back.
// After reset the S_INIT state writes the whole-pool free block; o_req_ready is low meanwhile.
// Reset is synchronous, active low. A result held by i_rsp_ready keeps the sequencer in its
// final state; the next request may be taken while the previous result still waits.
module first_fit_block_allocator #(
    parameter int POOL_BYTES    = 4194304,
    parameter int TABLE_ENTRIES = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request
    input  wire logic        i_req_valid,
    output logic             o_req_ready,
    input  wire logic        i_opcode,
    input  wire logic [22:0] i_request_bytes,
    input  wire logic [21:0] i_block_offset,
    // response
    output logic             o_rsp_valid,
    input  wire logic        i_rsp_ready,
    output logic             o_ok,
    output logic [2:0]       o_status,
    output logic [21:0]      o_granted_offset,
    output logic [22:0]      o_free_bytes,
    output logic [22:0]      o_used_bytes,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata
);
    // SZ_W holds any offset or size in the pool; AW holds request arithmetic too.
    localparam int SZ_W = $clog2(POOL_BYTES + 1);
    localparam int AW   = ((SZ_W > 24) ? SZ_W : 24) + 1;
    localparam int IW   = $clog2(TABLE_ENTRIES);
    localparam int CW   = $clog2(TABLE_ENTRIES + 1);
    localparam int EW   = 2 * SZ_W + 1;   // {offset, size, free}

    ffba_pkg::t_state r_state, n_state;

    logic [7:0]      r_thr;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [SZ_W-1:0] r_free, n_free;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_j, n_j;
    logic            r_op, n_op;
    logic [AW-1:0]   r_rsize, n_rsize;
    logic [AW-1:0]   r_match, n_match;
    logic [SZ_W-1:0] r_off, n_off;
    logic [SZ_W-1:0] r_size, n_size;
    logic            r_rem_last, n_rem_last;
    logic            r_ok, n_ok;
    ffba_pkg::t_status r_st, n_st;
    logic [SZ_W-1:0] r_grant, n_grant;

    logic            r_rsp_valid, n_rsp_valid;
    logic            r_rsp_ok, n_rsp_ok;
    ffba_pkg::t_status r_rsp_st, n_rsp_st;
    logic [21:0]     r_rsp_grant, n_rsp_grant;
    logic [22:0]     r_rsp_free, n_rsp_free;
    logic [22:0]     r_rsp_used, n_rsp_used;

    // table RAM port
    logic            ram_we;
    logic [IW-1:0]   ram_waddr, ram_raddr;
    logic [EW-1:0]   ram_wdata, ram_rdata;

    logic [SZ_W-1:0] rd_off, rd_size;
    logic            rd_free;
    logic [AW-1:0]   rd_size_x, rd_off_x, free_x;
    logic [CW-1:0]   idx_p1, idx_m1;

    assign rd_off    = ram_rdata[EW-1:SZ_W+1];
    assign rd_size   = ram_rdata[SZ_W:1];
    assign rd_free   = ram_rdata[0];
    assign rd_size_x = AW'(rd_size);
    assign rd_off_x  = AW'(rd_off);
    assign free_x    = AW'(r_free);
    assign idx_p1    = r_idx + CW'(1);
    assign idx_m1    = r_idx - CW'(1);

    ffba_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffba_pkg::S_INIT;
            r_thr       <= ffba_pkg::THRESHOLD_RESET;
            r_cnt       <= CW'(1);
            r_free      <= SZ_W'(POOL_BYTES);
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_free      <= n_free;
            r_rsp_valid <= n_rsp_valid;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_j         <= n_j;
        r_op        <= n_op;
        r_rsize     <= n_rsize;
        r_match     <= n_match;
        r_off       <= n_off;
        r_size      <= n_size;
        r_rem_last  <= n_rem_last;
        r_ok        <= n_ok;
        r_st        <= n_st;
        r_grant     <= n_grant;
        r_rsp_ok    <= n_rsp_ok;
        r_rsp_st    <= n_rsp_st;
        r_rsp_grant <= n_rsp_grant;
        r_rsp_free  <= n_rsp_free;
        r_rsp_used  <= n_rsp_used;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_free      = r_free;
        n_idx       = r_idx;
        n_j         = r_j;
        n_op        = r_op;
        n_rsize     = r_rsize;
        n_match     = r_match;
        n_off       = r_off;
        n_size      = r_size;
        n_rem_last  = r_rem_last;
        n_ok        = r_ok;
        n_st        = r_st;
        n_grant     = r_grant;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        n_rsp_ok    = r_rsp_ok;
        n_rsp_st    = r_rsp_st;
        n_rsp_grant = r_rsp_grant;
        n_rsp_free  = r_rsp_free;
        n_rsp_used  = r_rsp_used;
        ram_we      = 1'b0;
        ram_waddr   = r_idx[IW-1:0];
        ram_wdata   = {r_off, r_size, 1'b1};
        ram_raddr   = r_idx[IW-1:0];
        o_req_ready = 1'b0;

        case (r_state)
            ffba_pkg::S_INIT: begin
                // whole pool as one free block
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = {SZ_W'(0), SZ_W'(POOL_BYTES), 1'b1};
                n_state   = ffba_pkg::S_IDLE;
            end
            ffba_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_op    = i_opcode;
                    n_idx   = '0;
                    n_rsize = (AW'(i_request_bytes) + AW'(7)) & ~AW'(7);
                    n_match = AW'(i_block_offset);
                    n_grant = '0;
                    if (i_opcode == ffba_pkg::OP_ALLOC && i_request_bytes == '0) begin
                        n_ok    = 1'b0;
                        n_st    = ffba_pkg::ST_ZERO_SIZE;
                        n_state = ffba_pkg::S_DONE;
                    end else begin
                        n_state = ffba_pkg::S_SCAN_RD;
                    end
                end
            end
            ffba_pkg::S_SCAN_RD: begin
                if (r_idx >= r_cnt) begin
                    n_ok    = 1'b0;
                    n_st    = (r_op == ffba_pkg::OP_ALLOC) ? ffba_pkg::ST_NO_FIT
                                                           : ffba_pkg::ST_NOT_FOUND;
                    n_state = ffba_pkg::S_DONE;
                end else begin
                    n_state = ffba_pkg::S_SCAN_CHK;
                end
            end
            ffba_pkg::S_SCAN_CHK: begin
                n_off  = rd_off;
                n_size = rd_size;
                n_ok   = 1'b1;
                n_st   = ffba_pkg::ST_DONE;
                if (r_op == ffba_pkg::OP_ALLOC) begin
                    if (rd_free && rd_size_x >= r_rsize) begin
                        if (rd_size_x > r_rsize + AW'(r_thr)) begin
                            if (r_cnt >= CW'(TABLE_ENTRIES)) begin
                                n_ok    = 1'b0;
                                n_st    = ffba_pkg::ST_FULL;
                                n_state = ffba_pkg::S_DONE;
                            end else begin
                                n_j     = r_cnt;
                                n_state = ffba_pkg::S_INS_RD;
                            end
                        end else begin
                            // whole block handed out
                            ram_we    = 1'b1;
                            ram_wdata = {rd_off, rd_size, 1'b0};
                            n_free    = r_free - rd_size;
                            n_grant   = rd_off;
                            n_state   = ffba_pkg::S_DONE;
                        end
                    end else begin
                        n_idx   = idx_p1;
                        n_state = ffba_pkg::S_SCAN_RD;
                    end
                end else begin
                    if (rd_off_x == r_match) begin
                        if (!rd_free) begin
                            n_free = r_free + rd_size;
                        end
                        n_state = ffba_pkg::S_NXT_RD;
                    end else begin
                        n_idx   = idx_p1;
                        n_state = ffba_pkg::S_SCAN_RD;
                    end
                end
            end
            // open a gap at idx+1, moving entries up from the tail
            ffba_pkg::S_INS_RD: begin
                ram_raddr = IW'(r_j - CW'(1));
                if (r_j > idx_p1) begin
                    n_state = ffba_pkg::S_INS_WR;
                end else begin
                    n_state = ffba_pkg::S_SPLIT_HI;
                end
            end
            ffba_pkg::S_INS_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[IW-1:0];
                ram_wdata = ram_rdata;
                n_j       = r_j - CW'(1);
                n_state   = ffba_pkg::S_INS_RD;
            end
            ffba_pkg::S_SPLIT_HI: begin
                ram_we    = 1'b1;
                ram_waddr = idx_p1[IW-1:0];
                ram_wdata = {r_off + SZ_W'(r_rsize), r_size - SZ_W'(r_rsize), 1'b1};
                n_state   = ffba_pkg::S_SPLIT_LO;
            end
            ffba_pkg::S_SPLIT_LO: begin
                ram_we    = 1'b1;
                ram_wdata = {r_off, SZ_W'(r_rsize), 1'b0};
                n_cnt     = r_cnt + CW'(1);
                n_free    = r_free - SZ_W'(r_rsize);
                n_grant   = r_off;
                n_state   = ffba_pkg::S_DONE;
            end
            // free: try the upper neighbour
            ffba_pkg::S_NXT_RD: begin
                ram_raddr = idx_p1[IW-1:0];
                if (idx_p1 < r_cnt) begin
                    n_state = ffba_pkg::S_NXT_CHK;
                end else begin
                    n_state = ffba_pkg::S_PRV_RD;
                end
            end
            ffba_pkg::S_NXT_CHK: begin
                if (rd_free) begin
                    n_size     = r_size + rd_size;
                    n_j        = idx_p1;
                    n_rem_last = 1'b0;
                    n_state    = ffba_pkg::S_REM_RD;
                end else begin
                    n_state = ffba_pkg::S_PRV_RD;
                end
            end
            // then the lower neighbour
            ffba_pkg::S_PRV_RD: begin
                ram_raddr = idx_m1[IW-1:0];
                if (r_idx == '0) begin
                    ram_we  = 1'b1;
                    n_state = ffba_pkg::S_DONE;
                end else begin
                    n_state = ffba_pkg::S_PRV_CHK;
                end
            end
            ffba_pkg::S_PRV_CHK: begin
                ram_we = 1'b1;
                if (rd_free) begin
                    ram_waddr  = idx_m1[IW-1:0];
                    ram_wdata  = {rd_off, rd_size + r_size, 1'b1};
                    n_j        = r_idx;
                    n_rem_last = 1'b1;
                    n_state    = ffba_pkg::S_REM_RD;
                end else begin
                    n_state = ffba_pkg::S_DONE;
                end
            end
            // close the gap at j, moving entries down
            ffba_pkg::S_REM_RD: begin
                ram_raddr = IW'(r_j + CW'(1));
                if ((r_j + CW'(1)) < r_cnt) begin
                    n_state = ffba_pkg::S_REM_WR;
                end else begin
                    n_cnt   = r_cnt - CW'(1);
                    n_state = r_rem_last ? ffba_pkg::S_DONE : ffba_pkg::S_PRV_RD;
                end
            end
            ffba_pkg::S_REM_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[IW-1:0];
                ram_wdata = ram_rdata;
                n_j       = r_j + CW'(1);
                n_state   = ffba_pkg::S_REM_RD;
            end
            ffba_pkg::S_DONE: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_rsp_valid = 1'b1;
                    n_rsp_ok    = r_ok;
                    n_rsp_st    = r_st;
                    n_rsp_grant = r_ok ? 22'(AW'(r_grant)) : '0;
                    n_rsp_free  = 23'(free_x);
                    n_rsp_used  = 23'(AW'(POOL_BYTES) - free_x);
                    n_state     = ffba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffba_pkg::S_IDLE;
            end
        endcase
    end

    assign o_rsp_valid      = r_rsp_valid;
    assign o_ok             = r_rsp_ok;
    assign o_status         = r_rsp_st;
    assign o_granted_offset = r_rsp_grant;
    assign o_free_bytes     = r_rsp_free;
    assign o_used_bytes     = r_rsp_used;

    // table never empty, never over capacity
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) && (r_cnt <= CW'(TABLE_ENTRIES)))
        else $error("block count out of range");

    // free byte count never exceeds the pool
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        AW'(r_free) <= AW'(POOL_BYTES))
        else $error("free total exceeds pool");

    // a successful result always carries the done status
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && r_rsp_ok) |-> (r_rsp_st == ffba_pkg::ST_DONE))
        else $error("ok with error status");

    // a request is only taken by the idle sequencer, which then leaves idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_state != ffba_pkg::S_IDLE))
        else $error("request taken without starting work");

endmodule
`default_nettype wire
